// ===== rtl/irqfiq_pkg.sv =====
// ----------------------------------------------------------------------------
// irqfiq_pkg
// Shared types and constants for the IRQ/FIQ interrupt controller.
// ----------------------------------------------------------------------------
package irqfiq_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned HELD_W   = 14;
   localparam int unsigned STATUS_W = 10;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned INDEX_W  = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_HELD   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_STATUS = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ENABLE = 3'd2;
   localparam logic [INDEX_W-1:0] REG_MASK   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_ACK    = 3'd4;

   // held-bit selections for the two request outputs
   localparam logic [HELD_W-1:0]   IRQ_SEL    = 14'h1fbf;
   localparam logic [HELD_W-1:0]   FIQ_SEL    = 14'h2040;
   // sources that show up in status
   localparam logic [STATUS_W-1:0] STATUS_SEL = 10'h21f;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] reg_index;
      logic [DATA_W-1:0]  write_data;
      logic [DATA_W-1:0]  byte_mask;
      logic [HELD_W-1:0]  source_lines;
      logic               level;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_out;
      logic              fiq_out;
   } rsp_payload_type;

endpackage

// ===== rtl/irqfiq_if.sv =====
// ----------------------------------------------------------------------------
// irqfiq_req_if / irqfiq_rsp_if
// Valid/ready channels for controller requests and responses.
// ----------------------------------------------------------------------------
interface irqfiq_req_if import irqfiq_pkg::*; ;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface irqfiq_rsp_if import irqfiq_pkg::*; ;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/interrupt_controller_irq_fiq_unit.sv =====
// The response is registered and becomes valid in the cycle after the request is accepted.
// Throughput: one transaction per cycle; the response register decouples the
// two sides, so a new request is taken whenever the response slot is free or
// is being drained in the same cycle.
// Reset: synchronous, active high; clears held, status, enable and mask
// registers and the response valid flag.
// ----------------------------------------------------------------------------
// interrupt_controller_irq_fiq_unit
// Memory-mapped interrupt controller with held/status/enable/mask registers
// and separate IRQ and FIQ request outputs.
// ----------------------------------------------------------------------------
module interrupt_controller_irq_fiq_unit import irqfiq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   irqfiq_req_if.sink    req_chan,
   irqfiq_rsp_if.source  rsp_chan
);

   logic [HELD_W-1:0]   held_ff,   held_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   enable_ff, enable_in;
   logic [DATA_W-1:0]   mask_ff,   mask_in;

   logic                rsp_valid_ff;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                accept;
   req_payload_type     req;
   logic [DATA_W-1:0]   merged_en;
   logic [DATA_W-1:0]   merged_mask;
   logic [HELD_W-1:0]   raise_held;

   assign req            = req_chan.data;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign merged_en   = (enable_ff & ~req.byte_mask) | (req.write_data & req.byte_mask);
   assign merged_mask = (mask_ff & ~req.byte_mask) | (req.write_data & req.byte_mask);
   assign raise_held  = req.source_lines & enable_ff[HELD_W-1:0] & ~mask_ff[HELD_W-1:0];

   always_comb begin
      held_in   = held_ff;
      status_in = status_ff;
      enable_in = enable_ff;
      mask_in   = mask_ff;
      rsp_data_in.read_data = '0;

      case (req.cmd)
         CMD_READ: begin
            unique case (req.reg_index)
               REG_HELD:   rsp_data_in.read_data = {{(DATA_W-HELD_W){1'b0}}, held_ff};
               REG_STATUS: rsp_data_in.read_data = {{(DATA_W-STATUS_W){1'b0}}, status_ff};
               REG_ENABLE: rsp_data_in.read_data = enable_ff;
               default:    rsp_data_in.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            unique case (req.reg_index)
               REG_ENABLE: begin
                  enable_in = merged_en;
                  mask_in   = mask_ff & ~merged_en;
               end
               REG_MASK: begin
                  mask_in   = merged_mask;
                  enable_in = enable_ff & ~merged_mask;
               end
               REG_ACK: begin
                  // acknowledge uses the whole word, lanes ignored
                  held_in   = held_ff & ~req.write_data[HELD_W-1:0];
                  status_in = status_ff & ~req.write_data[STATUS_W-1:0];
               end
               default: ;
            endcase
         end
         CMD_EVENT: begin
            if (req.level) begin
               status_in = status_ff | (req.source_lines[STATUS_W-1:0] & STATUS_SEL);
               held_in   = held_ff | raise_held;
            end else begin
               status_in = status_ff & ~req.source_lines[STATUS_W-1:0];
            end
         end
         default: ;
      endcase

      rsp_data_in.irq_out = |(held_in & IRQ_SEL);
      rsp_data_in.fiq_out = |(held_in & FIQ_SEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         status_ff    <= '0;
         enable_ff    <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            held_ff      <= held_in;
            status_ff    <= status_in;
            enable_ff    <= enable_in;
            mask_ff      <= mask_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== verif/tb_interrupt_controller_irq_fiq_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interrupt_controller_irq_fiq_unit
// Drives bus reads, writes, acknowledges and line events into the IRQ/FIQ
// controller with random idling on both channels. A scoreboard class tracks
// held/status/enable/mask and checks every response in order.
// ----------------------------------------------------------------------------
module tb_interrupt_controller_irq_fiq_unit import irqfiq_pkg::*; ;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_ITEMS     = 700;
   localparam int LONG_HOLD_ITEM   = 250;
   localparam int DRAIN_ITEM       = 450;
   localparam int QUIET_ITEM       = 600;
   localparam int LONG_HOLD_CYCLES = 300;

   class irq_fiq_scoreboard;
      logic [HELD_W-1:0]   held;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   enable;
      logic [DATA_W-1:0]   mask;
      rsp_payload_type     predicted_rsp[$];
      int                  error_count;

      function new();
         held        = '0;
         status      = '0;
         enable      = '0;
         mask        = '0;
         error_count = 0;
      endfunction

      function int pending();
         return predicted_rsp.size();
      endfunction

      // updates register state for one accepted request and queues its response
      function void apply_request(req_payload_type r);
         rsp_payload_type want;
         want.read_data = '0;
         case (r.cmd)
            CMD_READ: begin
               case (r.reg_index)
                  REG_HELD:   want.read_data = DATA_W'(held);
                  REG_STATUS: want.read_data = DATA_W'(status);
                  REG_ENABLE: want.read_data = enable;
                  default:    want.read_data = '0;
               endcase
            end
            CMD_WRITE: begin
               case (r.reg_index)
                  REG_ENABLE: begin
                     enable = (enable & ~r.byte_mask) | (r.write_data & r.byte_mask);
                     mask   = mask & ~enable;
                  end
                  REG_MASK: begin
                     mask   = (mask & ~r.byte_mask) | (r.write_data & r.byte_mask);
                     enable = enable & ~mask;
                  end
                  REG_ACK: begin
                     // acknowledge uses the whole word, lanes do not apply
                     held   = held & ~r.write_data[HELD_W-1:0];
                     status = status & ~r.write_data[STATUS_W-1:0];
                  end
                  default: ;
               endcase
            end
            CMD_EVENT: begin
               if (r.level) begin
                  status = status | (r.source_lines[STATUS_W-1:0] & STATUS_SEL);
                  held   = held | (r.source_lines & enable[HELD_W-1:0] & ~mask[HELD_W-1:0]);
               end else begin
                  status = status & ~r.source_lines[STATUS_W-1:0];
               end
            end
            default: ;
         endcase
         want.irq_out = |(held & IRQ_SEL);
         want.fiq_out = |(held & FIQ_SEL);
         predicted_rsp.push_back(want);
      endfunction

      function void log_error(string what, rsp_payload_type want, rsp_payload_type got);
         error_count++;
         if (error_count <= 10)
            $display("%0t ERROR %s: expected data=%h irq=%b fiq=%b, got data=%h irq=%b fiq=%b",
                     $realtime, what, want.read_data, want.irq_out, want.fiq_out,
                     got.read_data, got.irq_out, got.fiq_out);
      endfunction

      function void compare_response(rsp_payload_type got);
         rsp_payload_type want;
         if (predicted_rsp.size() == 0) begin
            want = '0;
            log_error("response with nothing outstanding", want, got);
            return;
         end
         want = predicted_rsp.pop_front();
         if (got.read_data !== want.read_data)
            log_error("read_data mismatch", want, got);
         else if (got.irq_out !== want.irq_out)
            log_error("irq_out mismatch", want, got);
         else if (got.fiq_out !== want.fiq_out)
            log_error("fiq_out mismatch", want, got);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   bit   quiet       = 1'b0;
   bit   long_hold   = 1'b0;

   irq_fiq_scoreboard sb = new();

   irqfiq_req_if req_if();
   irqfiq_rsp_if rsp_if();

   interrupt_controller_irq_fiq_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            sb.compare_response(rsp_if.data);
         if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return DATA_W'(32'hff) << (8 * $urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [HELD_W-1:0] random_lines();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return HELD_W'(1) << $urandom_range(0, HELD_W - 1);
         default: return HELD_W'($urandom());
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int pick;
      r.write_data   = random_word();
      r.byte_mask    = random_word();
      r.source_lines = random_lines();
      r.level        = 1'($urandom_range(0, 1));
      r.reg_index    = INDEX_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         r.cmd = CMD_READ;
         if ($urandom_range(0, 4) != 0)
            r.reg_index = REG_HELD + INDEX_W'($urandom_range(0, 2));
      end else if (pick < 55) begin
         r.cmd = CMD_WRITE;
         if ($urandom_range(0, 4) != 0)
            r.reg_index = REG_ENABLE + INDEX_W'($urandom_range(0, 2));
      end else if (pick < 92) begin
         r.cmd = CMD_EVENT;
      end else begin
         r.cmd = CMD_NOP;
      end
      return r;
   endfunction

   task automatic send_req(input req_payload_type r);
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.apply_request(r);
   endtask

   task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] lanes,
                              input logic [HELD_W-1:0] lines, input logic lvl);
      req_payload_type r;
      r.cmd          = cmd;
      r.reg_index    = idx;
      r.write_data   = wdata;
      r.byte_mask    = lanes;
      r.source_lines = lines;
      r.level        = lvl;
      send_req(r);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reads after reset, including unmapped and write-only indexes
      send_fields(CMD_READ,  REG_HELD,         '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_STATUS,       '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_ENABLE,       '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_MASK,         '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_ACK,          '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_ACK + 3'd3,   '0, '0, '0, 1'b0);
      send_fields(CMD_WRITE, REG_ENABLE,       '1, '1, '0, 1'b0);
      send_fields(CMD_READ,  REG_ENABLE,       '0, '0, '0, 1'b0);
      // mask write knocks the FIQ sources out of enable
      send_fields(CMD_WRITE, REG_MASK,         32'h0000_2040, '1, '0, 1'b0);
      send_fields(CMD_READ,  REG_ENABLE,       '0, '0, '0, 1'b0);
      send_fields(CMD_EVENT, REG_HELD,         '0, '0, '1, 1'b1);
      send_fields(CMD_READ,  REG_HELD,         '0, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_STATUS,       '0, '0, '0, 1'b0);
      send_fields(CMD_EVENT, REG_HELD,         '1, '1, '0, 1'b1);
      send_fields(CMD_EVENT, REG_HELD,         '0, '0, 14'h0001, 1'b0);
      send_fields(CMD_WRITE, REG_HELD,         '1, '1, '0, 1'b1);
      send_fields(CMD_WRITE, REG_STATUS,       '0, '1, '0, 1'b0);
      send_fields(CMD_WRITE, REG_ACK + 3'd1,   '1, '1, '1, 1'b1);
      // acknowledge with all lanes off still clears
      send_fields(CMD_WRITE, REG_ACK,          32'h0000_0001, '0, '0, 1'b0);
      send_fields(CMD_WRITE, REG_MASK,         '0, 32'h0000_ff00, '0, 1'b0);
      send_fields(CMD_WRITE, REG_ENABLE,       32'h0000_2000, 32'h0000_ff00, '0, 1'b0);
      send_fields(CMD_EVENT, REG_HELD,         '0, '0, 14'h2000, 1'b1);
      send_fields(CMD_NOP,   REG_ENABLE,       '1, '1, '1, 1'b1);
      send_fields(CMD_WRITE, REG_ACK,          '1, '0, '0, 1'b0);
      send_fields(CMD_READ,  REG_HELD,         '0, '0, '0, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == LONG_HOLD_ITEM)
            long_hold = 1'b1;
         if (i == DRAIN_ITEM)
            wait_drained();
         if (i == QUIET_ITEM)
            quiet = 1'b1;
         send_req(random_request());
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== interrupt_controller_irq_fiq_unit.f =====
rtl/irqfiq_pkg.sv
rtl/irqfiq_if.sv
rtl/interrupt_controller_irq_fiq_unit.sv
verif/tb_interrupt_controller_irq_fiq_unit.sv
